// ----- sv/swm_pkg.sv -----
package swm_pkg;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int LEN_W        = 6;
  localparam int IDX_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_RESET    = 32;
  localparam int LEN_RESET_CL = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // one slot of the sorted window: value and how many samples ago it arrived
  typedef struct packed {
    sample_t val;
    idx_t    age;
  } cell_t;

  typedef struct packed {
    logic    clear;
    logic    shift;
    idx_t    len_m1;
    sample_t sample;
  } cell_ctl_t;

  localparam idx_t LEN_M1_RESET = idx_t'(LEN_RESET_CL - 1);

endpackage

// ----- sv/swm_sample_if.sv -----
interface swm_sample_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- sv/swm_median_if.sv -----
interface swm_median_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

// ----- sv/swm_cell.sv -----
module swm_cell
  import swm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  idx_t      idx,
  input  logic      has_prev,
  input  cell_ctl_t ctl,
  input  cell_t     prev_cell,
  input  cell_t     next_cell,
  input  logic      del_in,
  output cell_t     slot,
  output logic      del_out
);

  cell_t cell_r, cell_nxt;
  cell_t c_own, c_prev;
  logic  active, last, own_gt, prev_gt;

  assign active  = (idx <= ctl.len_m1);
  assign last    = (idx == ctl.len_m1);
  // deleted slot lies at or below this cell
  assign del_out = del_in | (active & (cell_r.age == ctl.len_m1));

  // window with the oldest removed, at this slot and the one below
  assign c_own  = del_out ? next_cell : cell_r;
  assign c_prev = del_in ? cell_r : prev_cell;

  assign own_gt  = !last && (c_own.val > ctl.sample);
  assign prev_gt = has_prev && (c_prev.val > ctl.sample);

  always_comb begin
    cell_nxt = cell_r;
    if (ctl.clear) begin
      cell_nxt.val = '0;
      cell_nxt.age = idx;
    end else if (ctl.shift && active) begin
      if (prev_gt) begin
        cell_nxt.val = c_prev.val;
        cell_nxt.age = c_prev.age + idx_t'(1);
      end else if (own_gt || last) begin
        cell_nxt.val = ctl.sample;
        cell_nxt.age = '0;
      end else begin
        cell_nxt.val = c_own.val;
        cell_nxt.age = c_own.age + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.val <= '0;
      cell_r.age <= idx;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign slot = cell_r;

endmodule

// ----- sv/swm_chain.sv -----
module swm_chain
  import swm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  idx_t      mid,
  output sample_t   median,
  output logic      del_found
);

  cell_t cells [MAX_WINDOW];
  logic  dels  [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_t prev_c, next_c;
    logic  del_prev;

    if (i == 0) begin : g_first
      assign prev_c   = '0;
      assign del_prev = 1'b0;
    end else begin : g_mid
      assign prev_c   = cells[i-1];
      assign del_prev = dels[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (idx_t'(i)),
      .has_prev  (i != 0),
      .ctl       (ctl),
      .prev_cell (prev_c),
      .next_cell (next_c),
      .del_in    (del_prev),
      .slot      (cells[i]),
      .del_out   (dels[i])
    );
  end

  assign median    = cells[mid].val;
  assign del_found = dels[MAX_WINDOW-1];

endmodule

// ----- sv/sliding_window_median_core.sv -----
// Running median over the last window_length samples (1..32, reset 32; a write of 0 acts as 1,
// above 32 acts as 32). The window is kept sorted in a row of compare-and-shift cells that absorb
// a request in parallel; acceptance updates the cells and a pending flag, then the output register
// takes the median once free. One request per cycle is sustained while the output is drained. Any
// write of cfg_wdata clears the window to zeros; write only while no request is in flight.
module sliding_window_median_core
  import swm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  swm_sample_if.sink        in_if,
  swm_median_if.source      out_if,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata
);

  idx_t      len_m1_r, len_m1_nxt;
  logic      pend_r, pend_nxt;
  logic      ov_r, ov_nxt;
  sample_t   median_r, median_nxt;
  logic      acc, load, del_found;
  sample_t   median;
  cell_ctl_t ctl;
  idx_t      mid;

  assign load        = pend_r && (!ov_r || out_if.ready);
  assign in_if.ready = !pend_r || load;
  assign acc         = in_if.valid && in_if.ready;
  assign mid         = len_m1_r >> 1;

  assign ctl.clear  = cfg_we;
  assign ctl.shift  = acc;
  assign ctl.len_m1 = len_m1_r;
  assign ctl.sample = in_if.sample;

  swm_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .mid       (mid),
    .median    (median),
    .del_found (del_found)
  );

  always_comb begin
    len_m1_nxt = len_m1_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len_m1_nxt = '0;
      end else if (int'(cfg_wdata) > MAX_WINDOW) begin
        len_m1_nxt = idx_t'(MAX_WINDOW - 1);
      end else begin
        len_m1_nxt = idx_t'(cfg_wdata - LEN_W'(1));
      end
    end
    pend_nxt   = acc ? 1'b1 : (load ? 1'b0 : pend_r);
    ov_nxt     = load ? 1'b1 : (out_if.ready ? 1'b0 : ov_r);
    median_nxt = load ? median : median_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r <= LEN_M1_RESET;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      len_m1_r <= len_m1_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_if.valid  = ov_r;
  assign out_if.median = median_r;

`ifndef SYNTHESIS
  a_oldest_found: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> del_found)
    else $error("no oldest slot in sorted window");

  a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> pend_r)
    else $error("accepted request not pending");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> ov_r && (median_r == $past(median)))
    else $error("median not loaded to output");
`endif

endmodule

// ----- verif/tb.sv -----
module tb;
  import swm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1050;
  localparam int QUIET_MAX = 2000;

  class median_scoreboard;
    sample_t     ring[MAX_WINDOW];
    sample_t     sorted_win[MAX_WINDOW];
    int unsigned wpos;
    int unsigned win_len;
    sample_t     median_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mismatches = 0;
      checked    = 0;
      set_length(LEN_W'(LEN_RESET));
    endfunction

    // 0 acts as 1, above MAX_WINDOW saturates; any write clears the window
    function void set_length(logic [LEN_W-1:0] v);
      int unsigned i;
      if (v < 1) begin
        win_len = 1;
      end else if (v > MAX_WINDOW) begin
        win_len = MAX_WINDOW;
      end else begin
        win_len = v;
      end
      for (i = 0; i < MAX_WINDOW; i++) begin
        ring[i]       = '0;
        sorted_win[i] = '0;
      end
      wpos = 0;
    endfunction

    function void note_sample(sample_t fresh);
      sample_t     oldest;
      int unsigned hole;
      int unsigned i;
      bit          found;
      oldest     = ring[wpos];
      ring[wpos] = fresh;
      hole  = win_len - 1;
      found = 0;
      for (i = 0; i < win_len; i++) begin
        if (!found && sorted_win[i] == oldest) begin
          hole  = i;
          found = 1;
        end
      end
      while (hole > 0 && sorted_win[hole-1] > fresh) begin
        sorted_win[hole] = sorted_win[hole-1];
        hole--;
      end
      while (hole + 1 < win_len && sorted_win[hole+1] < fresh) begin
        sorted_win[hole] = sorted_win[hole+1];
        hole++;
      end
      sorted_win[hole] = fresh;
      wpos = (wpos + 1 >= win_len) ? 0 : wpos + 1;
      median_q.push_back(sorted_win[(win_len-1)/2]);
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      if (median_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected median %0d, none pending", got);
        return;
      end
      want = median_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("median mismatch #%0d: expected %0d, got %0d", checked, want, got);
        end
      end
    endfunction

    function int pending();
      return median_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  swm_sample_if in_if();
  swm_median_if out_if();

  median_scoreboard sb = new();

  bit          idle_en;
  int unsigned n_in;
  int unsigned n_settings;
  int unsigned quiet;
  int unsigned stall_left;

  sliding_window_median_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    out_if.ready  = 1'b0;
    idle_en       = 1'b0;
    n_in          = 0;
    n_settings    = 1;
    quiet         = 0;
    stall_left    = 0;
  end

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(1, 3) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_sample(in_if.sample);
        n_in++;
      end
      if (out_if.valid && out_if.ready) sb.check_median(out_if.median);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_MAX) begin
        $display("watchdog: no request moved for %0d cycles", QUIET_MAX);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_sample(sample_t s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_length(logic [LEN_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_length(v);
    n_settings++;
  endtask

  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return sample_t'($urandom());
    if (r < 8) return sample_t'($signed($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 3))
      0: return sample_t'(16'sh7fff);
      1: return sample_t'(16'sh8000);
      2: return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count) send_sample(pick_sample());
  endtask

  initial begin
    int unsigned sent;
    int unsigned cnt;
    int unsigned ph;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_list[10];

    len_list = '{1, 2, 32, 31, 4, 7, 16, 0, 33, 63};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length: extremes and alternating bit patterns
    idle_en = 1'b1;
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);

    // zero length behaves as one
    load_length(0);
    send_sample(7);
    send_sample(-7);
    send_sample(16'sh7fff);

    // even length takes lower middle
    load_length(2);
    send_sample(3);
    send_sample(3);
    send_sample(-3);

    // oversize length saturates
    load_length(63);
    send_sample(100);
    send_sample(-100);

    // duplicates, then rewrite of the same length clears
    load_length(3);
    send_sample(5);
    send_sample(5);
    send_sample(5);
    send_sample(-2);
    load_length(3);
    send_sample(1);
    send_sample(-1);

    sent = 0;
    ph   = 0;
    while (sent < N_RANDOM - 60) begin
      len = (ph < 10) ? len_list[ph] : LEN_W'($urandom_range(0, 63));
      cnt = $urandom_range(40, 120);
      if (cnt > N_RANDOM - 60 - sent) cnt = N_RANDOM - 60 - sent;
      idle_en = ($urandom_range(0, 3) != 0);
      load_length(len);
      run_random(cnt);
      sent += cnt;
      ph++;
    end

    // closing stretch at full rate
    load_length(32);
    idle_en = 1'b0;
    run_random(60);

    drain();
    repeat (10) @(posedge clk);

    $display("%0d samples over %0d window settings, %0d medians checked, %0d mismatches",
             n_in, n_settings, sb.checked, sb.mismatches);
    if (sb.pending() > 0) $display("%0d medians never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
